>>> sv/abp_pkg.sv
package abp_pkg;

    localparam int NUM_PATTERNS = 3;
    localparam int ROM_ROWS     = 3;
    localparam int MAX_ROW      = (NUM_PATTERNS < ROM_ROWS) ? NUM_PATTERNS - 1 : ROM_ROWS - 1;

    localparam logic [11:0] ESCALATE_RESET = 12'd3000;
    localparam logic [2:0]  STOP_RESET     = 3'd6;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_START = 2'd1,
        REQ_STOP  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_ESCALATE = 2'd0,
        CFG_STOP     = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  seg_index;
        logic [7:0]  seg_count;
        logic [2:0]  level;
        logic [11:0] elapsed;
        logic        tone;
    } t_state;

    typedef struct packed {
        logic [11:0] escalate_ticks;
        logic [2:0]  stop_level;
    } t_cfg;

    // pattern row used for a level, saturating at the last pattern
    function automatic logic [1:0] row_for(input logic [2:0] lv);
        logic [2:0] r;
        r = lv;
        if (r > 3'(MAX_ROW)) r = 3'(MAX_ROW);
        return r[1:0];
    endfunction

    // row layout: segment count, then segment lengths in ticks
    function automatic logic [7:0] rom_at(input logic [1:0] row, input logic [2:0] pos);
        logic [7:0] v;
        v = 8'd0;
        unique case (row)
            2'd1: begin
                unique case (pos)
                    3'd0: v = 8'd6;
                    3'd1, 3'd2, 3'd3, 3'd4, 3'd5: v = 8'd10;
                    3'd6: v = 8'd50;
                    default: v = 8'd0;
                endcase
            end
            2'd2, 2'd3: begin
                unique case (pos)
                    3'd0: v = 8'd4;
                    3'd1, 3'd2, 3'd3, 3'd4: v = 8'd10;
                    default: v = 8'd0;
                endcase
            end
            default: begin
                unique case (pos)
                    3'd0: v = 8'd4;
                    3'd1: v = 8'd10;
                    3'd2: v = 8'd20;
                    3'd3: v = 8'd10;
                    3'd4: v = 8'd60;
                    default: v = 8'd0;
                endcase
            end
        endcase
        return v;
    endfunction

endpackage

>>> sv/abp_step.sv
module abp_step
    import abp_pkg::*;
(
    input  t_state     i_state,
    input  t_cfg       i_cfg,
    input  logic [1:0] i_req_type,
    input  logic [1:0] i_pattern_select,
    output t_state     o_state
);

    always_comb begin
        t_state     s;
        logic [2:0] lv;
        logic [1:0] row;
        logic [3:0] pos;
        logic       done;
        s    = i_state;
        lv   = 3'd0;
        row  = 2'd0;
        pos  = 4'd0;
        done = 1'b0;
        unique case (t_req'(i_req_type))
            REQ_TICK: begin
                if (s.seg_index != 3'd0) begin
                    s.elapsed = s.elapsed + 12'd1;
                    if (s.elapsed >= i_cfg.escalate_ticks) begin
                        s.elapsed = 12'd0;
                        if (s.level != 3'd7) s.level = s.level + 3'd1;
                        if ({1'b0, s.level} < 4'(NUM_PATTERNS)) begin
                            s.seg_index = 3'(rom_at(row_for(s.level), 3'd0) & 8'd7);
                            s.seg_count = 8'd1;
                        end else if (s.level >= i_cfg.stop_level) begin
                            // alarm runs out and switches itself off
                            s.seg_index = 3'd0;
                            s.tone      = 1'b0;
                            done        = 1'b1;
                        end
                    end
                    if (!done) begin
                        s.seg_count = s.seg_count - 8'd1;
                        if (s.seg_count == 8'd0) begin
                            row = row_for(s.level);
                            pos = {1'b0, s.seg_index} + 4'd1;
                            if ({4'd0, pos} > rom_at(row, 3'd0)) pos = 4'd1;
                            s.seg_index = pos[2:0];
                            s.seg_count = rom_at(row, pos[2:0]);
                            s.tone      = pos[0];
                        end
                    end
                end
            end
            REQ_START: begin
                if (s.seg_index == 3'd0) begin
                    lv = {1'b0, i_pattern_select};
                    if (lv > 3'(NUM_PATTERNS - 1)) lv = 3'(NUM_PATTERNS - 1);
                    s.level     = lv;
                    s.seg_index = 3'd1;
                    s.seg_count = rom_at(row_for(lv), 3'd1);
                    s.elapsed   = 12'd0;
                    s.tone      = 1'b1;
                end
            end
            REQ_STOP: begin
                s.seg_index = 3'd0;
                s.tone      = 1'b0;
            end
            default: begin
            end
        endcase
        o_state = s;
    end

endmodule

>>> sv/alarm_beep_pattern_sequencer.sv
// channel   | direction | handshake           | payload
// request   | in        | i_valid / o_stall   | i_req_type, i_pattern_select
// result    | out       | o_valid / i_stall   | o_tone_on, o_active
// config    | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// one request per cycle while o_stall is low; a request is registered in the input
// register, and its result is then held in the result register while i_stall is high
// synchronous active-low reset clears the alarm state and the valid flags
// o_stall rises only while the result register is full and i_stall holds it
module alarm_beep_pattern_sequencer
    import abp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [1:0]  i_pattern_select,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_tone_on,
    output logic        o_active,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic       r_in_valid;
    logic [1:0] r_req;
    logic [1:0] r_sel;
    t_state     r_state;
    t_state     n_state;
    t_cfg       r_cfg;
    logic       r_out_valid;
    logic       r_tone;
    logic       r_active;
    logic       adv;
    logic       take;

    assign adv     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !adv;
    assign take    = i_valid && !o_stall;

    abp_step u_step (
        .i_state          (r_state),
        .i_cfg            (r_cfg),
        .i_req_type       (r_req),
        .i_pattern_select (r_sel),
        .o_state          (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.escalate_ticks <= ESCALATE_RESET;
            r_cfg.stop_level     <= STOP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ESCALATE: r_cfg.escalate_ticks <= i_cfg_data;
                CFG_STOP:     r_cfg.stop_level     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (take) r_in_valid <= 1'b1;
            else if (adv) r_in_valid <= 1'b0;
            if (adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_req <= i_req_type;
            r_sel <= i_pattern_select;
        end
        if (adv) begin
            r_tone   <= n_state.tone;
            r_active <= (n_state.seg_index != 3'd0);
        end
    end

    assign o_valid   = r_out_valid;
    assign o_tone_on = r_tone;
    assign o_active  = r_active;

endmodule

>>> sv/abp_checker.sv
module abp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_tone_on,
    input logic        o_active
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tone_on) && $stable(o_active))
        else $error("held result changed");

    // the tone only sounds while the sequence runs
    a_tone_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tone_on |-> o_active)
        else $error("tone on while idle");

    // requests are held back only by a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without a held result");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("result or stall after reset");

endmodule

bind alarm_beep_pattern_sequencer abp_checker u_abp_checker (.*);

>>> tb/sv/alarm_beep_pattern_sequencer_tb.sv
`timescale 1ns / 1ps

module alarm_beep_pattern_sequencer_tb;
    import abp_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int PHASES      = 14;
    localparam int PER_PHASE   = 74;

    // segment count, then segment lengths in ticks
    localparam logic [7:0] PATTERN_ROM [3][8] = '{
        '{8'd4, 8'd10, 8'd20, 8'd10, 8'd60, 8'd0,  8'd0,  8'd0},
        '{8'd6, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd50, 8'd0},
        '{8'd4, 8'd10, 8'd10, 8'd10, 8'd10, 8'd0,  8'd0,  8'd0}
    };

    // escalation and stop settings for the first twelve random phases; the last two phases are drawn at random
    localparam int ESC_PLAN  [12] = '{1, 0, 2, 5, 4095, 8, 3, 20, 1, 12, 0, 30};
    localparam int STOP_PLAN [12] = '{1, 0, 7, 3, 7,    4, 6, 7,  5, 2,  7, 6};

    typedef struct packed {
        logic tone_on;
        logic active;
    } t_beep_result;

    class beep_scoreboard;
        logic [2:0]   seg_pos;
        logic [7:0]   seg_left;
        logic [2:0]   lvl;
        logic [11:0]  tick_cnt;
        logic         tone;
        logic [11:0]  escalate_ticks;
        logic [2:0]   stop_level;
        t_beep_result expected_q[$];
        int           errors;

        function new();
            seg_pos        = '0;
            seg_left       = '0;
            lvl            = '0;
            tick_cnt       = '0;
            tone           = 1'b0;
            escalate_ticks = ESCALATE_RESET;
            stop_level     = STOP_RESET;
            errors         = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [11:0] data);
            if (idx == CFG_ESCALATE) escalate_ticks = data;
            else if (idx == CFG_STOP) stop_level = data[2:0];
        endfunction

        function bit alarm_running();
            return seg_pos != 0;
        endfunction

        function int row_of(logic [2:0] lv);
            return (lv > NUM_PATTERNS - 1) ? NUM_PATTERNS - 1 : int'(lv);
        endfunction

        function void count_tick();
            int row;
            int nxt;
            if (seg_pos == 0) return;
            tick_cnt = tick_cnt + 12'd1;
            if (tick_cnt >= escalate_ticks) begin
                tick_cnt = '0;
                if (lvl < 3'd7) lvl = lvl + 3'd1;
                if (lvl < NUM_PATTERNS) begin
                    // park on the last segment so the countdown below restarts the pattern
                    seg_pos  = PATTERN_ROM[row_of(lvl)][0][2:0];
                    seg_left = 8'd1;
                end else if (lvl >= stop_level) begin
                    seg_pos = '0;
                    tone    = 1'b0;
                    return;
                end
            end
            seg_left = seg_left - 8'd1;
            if (seg_left == 0) begin
                row = row_of(lvl);
                nxt = seg_pos + 1;
                if (nxt > PATTERN_ROM[row][0]) nxt = 1;
                seg_pos  = nxt[2:0];
                seg_left = PATTERN_ROM[row][nxt & 7];
                tone     = nxt[0];
            end
        endfunction

        function void start_alarm(logic [1:0] sel);
            logic [2:0] first;
            if (seg_pos != 0) return;
            first    = (sel > NUM_PATTERNS - 1) ? 3'(NUM_PATTERNS - 1) : {1'b0, sel};
            lvl      = first;
            seg_pos  = 3'd1;
            seg_left = PATTERN_ROM[row_of(first)][1];
            tick_cnt = '0;
            tone     = 1'b1;
        endfunction

        // returns 1 when the request changed the alarm state
        function bit note_request(t_req kind, logic [1:0] sel);
            logic [26:0]  prior;
            t_beep_result res;
            prior = {seg_pos, seg_left, lvl, tick_cnt, tone};
            case (kind)
                REQ_TICK:  count_tick();
                REQ_START: start_alarm(sel);
                REQ_STOP: begin
                    seg_pos = '0;
                    tone    = 1'b0;
                end
                default: ;
            endcase
            res.tone_on = tone;
            res.active  = (seg_pos != 0);
            expected_q.push_back(res);
            return prior != {seg_pos, seg_left, lvl, tick_cnt, tone};
        endfunction

        function void check_result(logic tone_on, logic active);
            t_beep_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request waiting, tone_on %0b active %0b",
                         $time, tone_on, active);
                return;
            end
            want = expected_q.pop_front();
            if (want.tone_on !== tone_on) begin
                errors++;
                $display("%0t: tone_on expected %0b actual %0b",
                         $time, want.tone_on, tone_on);
            end
            if (want.active !== active) begin
                errors++;
                $display("%0t: active expected %0b actual %0b",
                         $time, want.active, active);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n          = 1'b0;
    logic        i_valid          = 1'b0;
    logic        o_stall;
    logic [1:0]  i_req_type       = '0;
    logic [1:0]  i_pattern_select = '0;
    logic        o_valid;
    logic        i_stall          = 1'b0;
    logic        o_tone_on;
    logic        o_active;
    logic        i_cfg_we         = 1'b0;
    logic [1:0]  i_cfg_index      = '0;
    logic [11:0] i_cfg_data       = '0;

    bit             steady = 1'b0;
    beep_scoreboard sb     = new();

    alarm_beep_pattern_sequencer DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_pattern_select (i_pattern_select),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_tone_on        (o_tone_on),
        .o_active         (o_active),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= i_rst_n && !steady && ($urandom_range(99) < 36);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_tone_on, o_active);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the request is taken
    task automatic send_req(t_req kind, logic [1:0] sel, output bit counted);
        while (!steady && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_req_type       <= kind;
        i_pattern_select <= sel;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        counted = sb.note_request(kind, sel);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(logic [11:0] esc, logic [2:0] stop);
        logic [11:0] stop_word;
        stop_word   = {9'($urandom_range(511)), stop};
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ESCALATE;
        i_cfg_data  <= esc;
        @(negedge i_clk);
        i_cfg_index <= CFG_STOP;
        i_cfg_data  <= stop_word;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(CFG_ESCALATE, esc);
        sb.set_reg(CFG_STOP, stop_word);
    endtask

    // mostly starts while silent and ticks while sounding, with some stops and noise
    task automatic random_requests(int want);
        int   done;
        int   roll;
        t_req kind;
        bit   counted;
        done = 0;
        while (done < want) begin
            roll = $urandom_range(99);
            if (!sb.alarm_running()) begin
                kind = (roll < 85) ? REQ_START : (roll < 92) ? REQ_TICK :
                       (roll < 96) ? REQ_STOP : REQ_NONE;
            end else begin
                kind = (roll < 84) ? REQ_TICK : (roll < 90) ? REQ_START :
                       (roll < 95) ? REQ_STOP : REQ_NONE;
            end
            send_req(kind, 2'($urandom_range(3)), counted);
            done++;
        end
    endtask

    initial begin
        bit counted;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // idle corner cases, ignored start, a full first segment, clamped select
        send_req(REQ_TICK,  2'd3, counted);
        send_req(REQ_STOP,  2'd0, counted);
        send_req(REQ_NONE,  2'd3, counted);
        send_req(REQ_START, 2'd0, counted);
        send_req(REQ_START, 2'd2, counted);
        repeat (10) send_req(REQ_TICK, 2'd1, counted);
        send_req(REQ_NONE,  2'd0, counted);
        send_req(REQ_STOP,  2'd1, counted);
        send_req(REQ_START, 2'd3, counted);
        send_req(REQ_TICK,  2'd2, counted);
        send_req(REQ_STOP,  2'd0, counted);
        send_req(REQ_START, 2'd1, counted);
        send_req(REQ_TICK,  2'd0, counted);
        send_req(REQ_STOP,  2'd3, counted);
        send_req(REQ_TICK,  2'd0, counted);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            steady = (p == 5 || p == 6);
            if (p < 12) set_config(12'(ESC_PLAN[p]), 3'(STOP_PLAN[p]));
            else set_config(12'($urandom_range(1, 40)), 3'($urandom_range(7)));
            random_requests(PER_PHASE);
            drain();
        end

        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
sv/abp_pkg.sv
sv/abp_step.sv
sv/alarm_beep_pattern_sequencer.sv
sv/abp_checker.sv
tb/sv/alarm_beep_pattern_sequencer_tb.sv
